@@ sv/vpbo_pkg.sv @@
// ============================================================================
// vpbo_pkg: shared types, constants and the quarter-wave sine function
// Holds the command and status structs between the controller and the
// datapath, the field widths of the stream beats and the sine polynomial.
// ============================================================================
package vpbo_pkg;

    // Field widths of the input and result beats
    localparam int TRIG_W    = 16;
    localparam int FREQ_W    = 20;
    localparam int LIMIT_W   = 8;
    localparam int DECAY_W   = 16;
    localparam int SAMPLE_W  = 16;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    // Bit positions of the input fields inside s_tdata
    localparam int TRIG_LSB  = 0;
    localparam int FREQ_LSB  = TRIG_LSB + TRIG_W;
    localparam int LIMIT_LSB = FREQ_LSB + FREQ_W;
    localparam int DECAY_LSB = LIMIT_LSB + LIMIT_W;

    // Configuration and arithmetic widths
    localparam int SCALE_W          = 32;
    localparam int PROD_W           = FREQ_W + SCALE_W;
    localparam int SCALE_SHIFT_BASE = 48;
    localparam int COUNT_W          = 9;
    localparam int MAG_W            = 15;
    localparam int SQ_W             = 2 * MAG_W;

    localparam logic [SCALE_W-1:0]  PHASE_SCALE_RESET = 32'd366503876;
    localparam logic [DECAY_W-1:0]  AMP_ONE           = 16'd32768;
    localparam logic [COUNT_W-1:0]  COUNT_MAX         = 9'd511;

    // Quarter-wave polynomial coefficients in Q30
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint SC1     = 64'sd1686629713;
    localparam longint SC3     = 64'sd693598670;
    localparam longint SC5     = 64'sd85569308;
    localparam longint SC7     = 64'sd5026995;
    localparam longint SC9     = 64'sd172272;
    localparam longint SC11    = 64'sd3864;
    localparam longint SC13    = 64'sd61;
    localparam longint HALF_Q15 = 64'sd16384;
    localparam longint MAG_MAX  = 64'sd32767;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic square;
        logic sample;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic run;
        logic start;
    } status_t;

    // Q30 product truncated toward zero.
    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b) / Q30_ONE;
    endfunction

    // Sine magnitude of quarter-wave step k, rounded to Q0.15. Only ever
    // evaluated with constant arguments, so it folds into a table.
    function automatic logic [MAG_W-1:0] quarter_sine(input int k, input int tbits);
        longint u;
        longint u2;
        longint p;
        longint s;
        longint r;
        u  = longint'(k) << (32 - tbits);
        u2 = mul_q30(u, u);
        p  = SC13;
        p  = mul_q30(p, u2) - SC11;
        p  = mul_q30(p, u2) + SC9;
        p  = mul_q30(p, u2) - SC7;
        p  = mul_q30(p, u2) + SC5;
        p  = mul_q30(p, u2) - SC3;
        p  = mul_q30(p, u2) + SC1;
        s  = mul_q30(p, u);
        if (s < 0) begin
            s = 0;
        end
        r = (s + HALF_Q15) >>> 15;
        if (r > MAG_MAX) begin
            r = MAG_MAX;
        end
        return r[MAG_W-1:0];
    endfunction

endpackage

@@ sv/vpbo_ctrl.sv @@
// ============================================================================
// vpbo_ctrl: sequencing controller
// Steps one accepted beat through table lookup, squaring, sample and decay,
// and owns the handshake of both stream channels.
// ============================================================================
module vpbo_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  vpbo_pkg::status_t st,
    output vpbo_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOKUP = 3'd1;
    localparam logic [2:0] ST_SQUARE = 3'd2;
    localparam logic [2:0] ST_SAMPLE = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       s_hs;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_hs     = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_hs;
                if (s_hs && (st.run || st.start)) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SAMPLE;
            end
            ST_SAMPLE: begin
                cmd.sample = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result of a beat is known at acceptance, so the output register
    // is loaded then and drains independently of the sequence.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_hs) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input beat taken while a result is stalled");

    a_work_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_hs && (st.run || st.start)) |=> (state_reg == ST_LOOKUP))
        else $error("working beat did not start the sequence");

    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |=> (state_reg == ST_IDLE))
        else $error("sequence did not return to idle after finish");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_hs))
        else $error("result appeared without an accepted beat");

endmodule

@@ sv/vpbo_datapath.sv @@
// ============================================================================
// vpbo_datapath: oscillator state and arithmetic
// Phase accumulator, quarter-wave sine table, squaring and amplitude decay
// multipliers, burst state and the phase scale register.
// ============================================================================
module vpbo_datapath #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  vpbo_pkg::cmd_t                      cmd,
    output vpbo_pkg::status_t                   st,
    input  logic [vpbo_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                cfg_valid,
    input  logic [vpbo_pkg::SCALE_W-1:0]        cfg_data,
    output logic [vpbo_pkg::SAMPLE_W-1:0]       out_sample
);

    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int AW      = SINE_TABLE_BITS - 1;
    localparam int INC_LSB = vpbo_pkg::SCALE_SHIFT_BASE - PHASE_BITS;
    localparam int SMP_W   = vpbo_pkg::SQ_W + vpbo_pkg::DECAY_W + 1;
    localparam int DEC_W   = 2 * vpbo_pkg::DECAY_W + 1;
    localparam logic [AW-1:0] QUARTER_A = AW'(QUARTER);

    // Quarter-wave table, one entry more than a quarter to hold the peak
    logic [vpbo_pkg::MAG_W-1:0] sine_rom [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
        assign sine_rom[g] = vpbo_pkg::quarter_sine(g, SINE_TABLE_BITS);
    end

    logic [vpbo_pkg::SCALE_W-1:0]   phase_scale_reg;
    logic [PHASE_BITS-1:0]          phase_reg;
    logic                           active_reg;
    logic                           was_high_reg;
    logic [vpbo_pkg::LIMIT_W-1:0]   limit_reg;
    logic [vpbo_pkg::DECAY_W-1:0]   decay_reg;
    logic [vpbo_pkg::DECAY_W-1:0]   amp_reg;
    logic [vpbo_pkg::COUNT_W-1:0]   count_reg;
    logic signed [15:0]             prev_sine_reg;
    logic [vpbo_pkg::SAMPLE_W-1:0]  held_reg;
    logic [vpbo_pkg::SAMPLE_W-1:0]  out_reg;

    logic [vpbo_pkg::FREQ_W-1:0]    freq_reg;
    logic                           run_reg;
    logic                           start_reg;
    logic [vpbo_pkg::MAG_W-1:0]     mag_reg;
    logic                           neg_reg;
    logic [vpbo_pkg::PROD_W-1:0]    prod_reg;
    logic signed [15:0]             sine_reg;
    logic [vpbo_pkg::SQ_W-1:0]      sq_reg;
    logic                           c1_reg;
    logic                           c2_reg;

    logic signed [vpbo_pkg::TRIG_W-1:0] trig;
    logic                           high;
    logic [SINE_TABLE_BITS-1:0]     idx;
    logic [AW-1:0]                  k_eff;
    logic signed [15:0]             sine_val;
    logic                           c1_val;
    logic                           c2_val;
    logic [SMP_W-1:0]               smp_sum;
    logic [vpbo_pkg::SAMPLE_W-1:0]  smp_sat;
    logic [DEC_W-1:0]               dec_sum;
    logic [vpbo_pkg::DECAY_W-1:0]   amp_decayed;
    logic [vpbo_pkg::COUNT_W-1:0]   count_inc;
    logic                           do_decay;
    logic [vpbo_pkg::COUNT_W-1:0]   count_after;

    assign trig     = s_tdata[vpbo_pkg::TRIG_LSB +: vpbo_pkg::TRIG_W];
    assign high     = !trig[vpbo_pkg::TRIG_W-1] && (trig != '0);
    assign st.run   = active_reg;
    assign st.start = !active_reg && high && !was_high_reg;

    // Table index: quadrant in the top two bits, odd quadrants mirrored.
    assign idx   = phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign k_eff = idx[SINE_TABLE_BITS-2] ?
                   (QUARTER_A - AW'(idx[SINE_TABLE_BITS-3:0])) :
                   AW'(idx[SINE_TABLE_BITS-3:0]);

    assign sine_val = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    // Crossings only count during a running burst; a zero sine after a zero
    // sine counts on both edges.
    assign c1_val = run_reg && !prev_sine_reg[15] && (sine_val[15] || (sine_val == '0));
    assign c2_val = run_reg && (prev_sine_reg[15] || (prev_sine_reg == '0)) && !sine_val[15];

    assign smp_sum = SMP_W'(sq_reg) * SMP_W'(amp_reg) + (SMP_W'(1) << 29);
    assign smp_sat = (smp_sum[SMP_W-1:46] != '0) ? '1 : smp_sum[45:30];

    assign dec_sum     = DEC_W'(amp_reg) * DEC_W'(decay_reg) + (DEC_W'(1) << 14);
    assign amp_decayed = (dec_sum[DEC_W-1:31] != '0) ? '1 : dec_sum[30:15];

    assign count_inc   = (count_reg == vpbo_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign do_decay    = (cmd.sample && c1_reg) || (cmd.finish && c2_reg);
    assign count_after = do_decay ? count_inc : count_reg;

    assign out_sample = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_scale_reg <= vpbo_pkg::PHASE_SCALE_RESET;
            phase_reg       <= '0;
            active_reg      <= 1'b0;
            was_high_reg    <= 1'b0;
            limit_reg       <= '0;
            decay_reg       <= '0;
            amp_reg         <= vpbo_pkg::AMP_ONE;
            count_reg       <= '0;
            prev_sine_reg   <= '0;
            held_reg        <= '0;
            run_reg         <= 1'b0;
            start_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                phase_scale_reg <= cfg_data;
            end
            if (cmd.accept) begin
                was_high_reg <= high;
                run_reg      <= active_reg;
                start_reg    <= st.start;
                if (st.start) begin
                    limit_reg <= s_tdata[vpbo_pkg::LIMIT_LSB +: vpbo_pkg::LIMIT_W];
                    decay_reg <= s_tdata[vpbo_pkg::DECAY_LSB +: vpbo_pkg::DECAY_W];
                    amp_reg   <= vpbo_pkg::AMP_ONE;
                    count_reg <= '0;
                end else if (!active_reg) begin
                    phase_reg <= '0;
                end
            end
            if (cmd.square) begin
                phase_reg <= phase_reg + prod_reg[INC_LSB +: PHASE_BITS];
            end
            if (cmd.sample) begin
                held_reg <= smp_sat;
            end
            if (do_decay) begin
                amp_reg   <= amp_decayed;
                count_reg <= count_inc;
            end
            if (cmd.finish) begin
                prev_sine_reg <= sine_reg;
                active_reg    <= start_reg || !(count_after > {1'b0, limit_reg});
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            out_reg  <= held_reg;
            freq_reg <= s_tdata[vpbo_pkg::FREQ_LSB +: vpbo_pkg::FREQ_W];
        end
        if (cmd.lookup) begin
            mag_reg  <= sine_rom[k_eff];
            neg_reg  <= idx[SINE_TABLE_BITS-1];
            prod_reg <= vpbo_pkg::PROD_W'(freq_reg) * vpbo_pkg::PROD_W'(phase_scale_reg);
        end
        if (cmd.square) begin
            sine_reg <= sine_val;
            sq_reg   <= vpbo_pkg::SQ_W'(mag_reg) * vpbo_pkg::SQ_W'(mag_reg);
            c1_reg   <= c1_val;
            c2_reg   <= c2_val;
        end
    end

endmodule

@@ sv/vosim_pulse_burst_oscillator.sv @@
// ============================================================================
// vosim_pulse_burst_oscillator: pulse-burst oscillator, one sample per beat
// Top level joining the sequencing controller and the oscillator datapath.
// ============================================================================
// Usage:
//   Each beat on the s_ channel carries one audio sample's controls (trigger
//   level, frequency in sixteenths of a hertz, half-cycle limit, decay). Each
//   accepted beat yields exactly one beat on the m_ channel: the sample that
//   the previous input beat computed, so output lags input by one beat.
//   The result is registered at acceptance and appears on the next cycle.
//   A beat that does work steps through accept, table read, square, sample
//   with first decay, then second decay and burst update; the two decay
//   steps share one multiplier and the sine table has one registered read.
//   A beat while idle with no rising trigger is done at the accept step.
//   While a result waits on a stalled m_ channel the block finishes its
//   current beat but takes no new one until the result drains.
//   cfg_ writes set the phase scale and are always ready; write only while
//   the block is idle. Reset clears the burst state, phase, held sample and
//   m_tvalid, restores amplitude to one and the phase scale to its default.
// ============================================================================
module vosim_pulse_burst_oscillator #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // trigger_level[15:0], freq_sixteenths[35:16], half_cycle_limit[43:36],
    // decay_factor[59:44], zero padding[63:60]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sample_out[15:0]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    vpbo_pkg::cmd_t    cmd;
    vpbo_pkg::status_t st;
    logic              cfg_hs;

    assign cfg_ready = 1'b1;
    assign cfg_hs    = cfg_valid && cfg_ready;

    vpbo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    vpbo_datapath #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .st         (st),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_hs),
        .cfg_data   (cfg_data),
        .out_sample (m_tdata)
    );

endmodule
